[src/sha1h_pkg.sv]
// Shared types, constants and round helpers for the SHA-1 stream hash unit.
`default_nettype none

package sha1h_pkg;

  localparam logic [31:0] IV_H0 = 32'h6745_2301;
  localparam logic [31:0] IV_H1 = 32'hefcd_ab89;
  localparam logic [31:0] IV_H2 = 32'h98ba_dcfe;
  localparam logic [31:0] IV_H3 = 32'h1032_5476;
  localparam logic [31:0] IV_H4 = 32'hc3d2_e1f0;

  localparam logic [31:0] K_R0 = 32'h5a82_7999;
  localparam logic [31:0] K_R1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_R2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K_R3 = 32'hca62_c1d6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Word slot of the block where the 64-bit length starts.
  localparam logic [3:0] LEN_WORD = 4'd14;

  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [6:0] LAST_ROUND = 7'd79;

  // One message word on its way from the front to the compression core.
  typedef struct packed {
    logic [31:0] word;
    logic        msg_end;
  } q_word_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t inside {[7'd0:7'd19]}) k = K_R0;
    else if (t inside {[7'd20:7'd39]}) k = K_R1;
    else if (t inside {[7'd40:7'd59]}) k = K_R2;
    else k = K_R3;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t inside {[7'd0:7'd19]}) f = (b & c) | (~b & d);
    else if (t inside {[7'd40:7'd59]}) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

endpackage

`default_nettype wire

[src/sha1h_front.sv]
// Front end: packs message bytes into words, appends padding and length.
`default_nettype none

module sha1h_front
  import sha1h_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_has_byte,
  input  wire logic       in_is_last,
  output logic            push,
  output q_word_t         push_data,
  input  wire logic       q_full
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_PAD   = 3'd1;
  localparam logic [2:0] F_ZERO  = 3'd2;
  localparam logic [2:0] F_LENHI = 3'd3;
  localparam logic [2:0] F_LENLO = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  nb_r, nb_nxt;
  logic [3:0]  wcnt_r, wcnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  wcnt_inc;
  logic [31:0] pad_word;

  assign wcnt_inc = 4'(wcnt_r + 4'd1);
  assign in_ready = (st_r == F_IDLE) && !q_full;

  always_comb begin
    case (nb_r)
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {acc_r[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {acc_r[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {acc_r[23:0], PAD_BYTE};
    endcase
  end

  always_comb begin
    st_nxt    = st_r;
    acc_nxt   = acc_r;
    nb_nxt    = nb_r;
    wcnt_nxt  = wcnt_r;
    len_nxt   = len_r;
    push      = 1'b0;
    push_data = '0;
    case (st_r)
      F_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_has_byte) begin
            len_nxt = len_r + 64'd8;
            if (nb_r == 2'd3) begin
              push           = 1'b1;
              push_data.word = {acc_r, in_data_byte};
              wcnt_nxt       = wcnt_inc;
              nb_nxt         = 2'd0;
            end else begin
              acc_nxt = {acc_r[15:0], in_data_byte};
              nb_nxt  = 2'(nb_r + 2'd1);
            end
          end
          if (in_is_last) st_nxt = F_PAD;
        end
      end
      F_PAD: begin
        if (!q_full) begin
          push           = 1'b1;
          push_data.word = pad_word;
          wcnt_nxt       = wcnt_inc;
          st_nxt         = (wcnt_inc == LEN_WORD) ? F_LENHI : F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          push     = 1'b1;
          wcnt_nxt = wcnt_inc;
          if (wcnt_inc == LEN_WORD) st_nxt = F_LENHI;
        end
      end
      F_LENHI: begin
        if (!q_full) begin
          push           = 1'b1;
          push_data.word = len_r[63:32];
          wcnt_nxt       = wcnt_inc;
          st_nxt         = F_LENLO;
        end
      end
      F_LENLO: begin
        if (!q_full) begin
          push              = 1'b1;
          push_data.word    = len_r[31:0];
          push_data.msg_end = 1'b1;
          wcnt_nxt          = 4'd0;
          nb_nxt            = 2'd0;
          len_nxt           = 64'd0;
          st_nxt            = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      nb_r   <= 2'd0;
      wcnt_r <= 4'd0;
      len_r  <= 64'd0;
    end else begin
      st_r   <= st_nxt;
      nb_r   <= nb_nxt;
      wcnt_r <= wcnt_nxt;
      len_r  <= len_nxt;
    end
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

[src/sha1h_fifo.sv]
// Word queue between the front end and the compression core.
`default_nettype none

module sha1h_fifo
  import sha1h_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire q_word_t push_data,
  output logic         full,
  output logic         q_valid,
  output q_word_t      q_data,
  input  wire logic    pop
);

  q_word_t        mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = (QAW+1)'(cnt_r + 1'b1);
    else if (do_pop && !do_push) cnt_nxt = (QAW+1)'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= QAW'(wp_r + 1'b1);
      if (do_pop) rp_r <= QAW'(rp_r + 1'b1);
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wp_r] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> cnt_r == (QAW+1)'($past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && cnt_r != (QAW+1)'(QDEPTH)) |-> wp_r != rp_r)
    else $error("queue pointers inconsistent with count");

endmodule

`default_nettype wire

[src/sha1h_core.sv]
// Compression core: loads a block, runs 80 rounds, chains and emits digest.
`default_nettype none

module sha1h_core
  import sha1h_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_word_t q_data,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_ready,
  output logic [31:0]  out_digest_word,
  output logic [2:0]   out_word_index,
  output logic         out_last_word
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_ROUND = 2'd1;
  localparam logic [1:0] S_ADD   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]  st_r;
  logic [3:0]  ld_r;
  logic [6:0]  rnd_r;
  logic [2:0]  ek_r;
  logic        fin_r;
  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic        ov_r;
  logic [31:0] od_r;
  logic [2:0]  oi_r;
  logic        ol_r;

  logic [31:0] w_new, w_mix, t_sum;
  logic        out_load;

  assign pop      = (st_r == S_LOAD) && q_valid;
  assign out_load = (st_r == S_EMIT) && (!ov_r || out_ready);

  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign t_sum = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
               + round_k(rnd_r) + w_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_LOAD;
      ld_r   <= 4'd0;
      rnd_r  <= 7'd0;
      ek_r   <= 3'd0;
      fin_r  <= 1'b0;
      ov_r   <= 1'b0;
      h_r[0] <= IV_H0;
      h_r[1] <= IV_H1;
      h_r[2] <= IV_H2;
      h_r[3] <= IV_H3;
      h_r[4] <= IV_H4;
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_LOAD: begin
          if (pop) begin
            if (q_data.msg_end) fin_r <= 1'b1;
            ld_r <= 4'(ld_r + 4'd1);
            if (ld_r == 4'd15) begin
              st_r  <= S_ROUND;
              rnd_r <= 7'd0;
            end
          end
        end
        S_ROUND: begin
          if (rnd_r == LAST_ROUND) st_r <= S_ADD;
          else rnd_r <= 7'(rnd_r + 7'd1);
        end
        S_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          ek_r   <= 3'd0;
          st_r   <= fin_r ? S_EMIT : S_LOAD;
        end
        S_EMIT: begin
          if (out_load) begin
            ek_r <= 3'(ek_r + 3'd1);
            if (ek_r == 3'd4) begin
              // digest is out: rewind the chain for the next message
              fin_r  <= 1'b0;
              st_r   <= S_LOAD;
              h_r[0] <= IV_H0;
              h_r[1] <= IV_H1;
              h_r[2] <= IV_H2;
              h_r[3] <= IV_H3;
              h_r[4] <= IV_H4;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  // Schedule shift line, round variables and output payload.
  always_ff @(posedge clk) begin
    if (pop || st_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= pop ? q_data.word : w_new;
    end
    if (pop && ld_r == 4'd15) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (st_r == S_ROUND) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (out_load) begin
      od_r <= h_r[ek_r];
      oi_r <= ek_r;
      ol_r <= (ek_r == 3'd4);
    end
  end

  assign out_valid       = ov_r;
  assign out_digest_word = od_r;
  assign out_word_index  = oi_r;
  assign out_last_word   = ol_r;

  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= LAST_ROUND)
    else $error("round counter overran");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT) |-> ek_r <= 3'd4)
    else $error("digest word index overran");

  a_last_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ek_r == 3'd4) |=> (st_r == S_LOAD && !fin_r && ov_r && ol_r))
    else $error("last digest word did not return core to load");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_LOAD) |-> !pop)
    else $error("queue popped outside block load");

endmodule

`default_nettype wire

[src/sha1_stream_hash_unit.sv]
// Top level of the byte-stream SHA-1 hash unit.
`default_nettype none

// SHA-1 over a byte stream. Each input transaction carries at most one
// message byte (in_has_byte) and may close the message (in_is_last); the
// byte of a closing transaction is hashed before the message is padded.
// A closing transaction yields five output transactions, H0 first, with
// out_last_word set on H4; the unit then starts over from the initial
// vector. The front end takes one byte per cycle while it is idle and the
// queue is not full, and packs bytes into 32-bit words that wait in a
// 16-word queue, so a whole next block can be filled while the core
// compresses. The core pulls the 16 words of a 64-byte block from the
// queue, runs the 80 rounds and then adds the result into the chain.
// Closing a message pushes the pad word, any zero words and the two
// length words (over a second block when the length does not fit), then
// the final block(s) are compressed and the digest words go out as the
// output side takes them. Digest words wait in an output register, and
// once H4 is held there the core loads again while the consumer stalls.
module sha1_stream_hash_unit
  import sha1h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_has_byte,
  input  wire logic        in_is_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic    push;
  q_word_t push_data;
  logic    q_full;
  logic    q_valid;
  q_word_t q_data;
  logic    pop;

  // Front: classify bytes, build words, append padding and bit length.
  sha1h_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_is_last   (in_is_last),
    .push         (push),
    .push_data    (push_data),
    .q_full       (q_full)
  );

  // Queue: hold up to one block of words between front and core.
  sha1h_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop)
  );

  // Back: compress each block and emit the digest.
  sha1h_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the byte-stream SHA-1 hash unit.
`default_nettype none

module testbench
  import sha1h_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One expected digest word, in the order the unit must emit them.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // ---------------------------------------------------------------------
  // DUT signals. Every input starts at a known value at time zero.
  // ---------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_has_byte  = 1'b0;
  logic        in_is_last   = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha1_stream_hash_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_has_byte     (in_has_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // ---------------------------------------------------------------------
  // Hash model state: chaining words, the partial block, its fill level
  // and the running bit length of the current message.
  // ---------------------------------------------------------------------
  logic [31:0] chain_h [5];
  logic [7:0]  block_buf [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  // Digest words predicted but not yet seen on the output side.
  digest_word_t pending_digest_words [$];

  int unsigned error_count   = 0;
  int unsigned words_checked = 0;
  int unsigned msgs_closed   = 0;
  int unsigned bytes_sent    = 0;
  int unsigned idle_sent     = 0;
  int unsigned longest_msg   = 0;
  int unsigned cur_msg_len   = 0;

  // Sender gaps are switched on and off per phase.
  bit sender_gaps = 1'b1;

  // Restart the model from the initial vector with an empty message.
  function automatic void sha1_restart();
    chain_h[0] = IV_H0;
    chain_h[1] = IV_H1;
    chain_h[2] = IV_H2;
    chain_h[3] = IV_H3;
    chain_h[4] = IV_H4;
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    block_fill = 0;
    msg_bits   = 64'd0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the chain.
  function automatic void sha1_compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        sum = w[(t+13)%16] ^ w[(t+8)%16] ^ w[(t+2)%16] ^ w[t%16];
        w[t%16] = {sum[30:0], sum[31]};
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w[t%16];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Absorb one accepted transaction; on a closing one, pad, finish and
  // queue the five digest words.
  function automatic void sha1_take_item(input logic [7:0] data, input logic has_byte,
                                         input logic is_last);
    digest_word_t dw;
    if (has_byte) begin
      block_buf[block_fill] = data;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == 64) begin
        sha1_compress_block();
        block_fill = 0;
      end
    end
    if (!is_last) return;
    block_buf[block_fill] = PAD_BYTE;
    block_fill++;
    // No room for the length: close this block and pad a second one.
    if (block_fill > 56) begin
      for (int i = block_fill; i < 64; i++) block_buf[i] = 8'h00;
      sha1_compress_block();
      block_fill = 0;
    end
    for (int i = block_fill; i < 56; i++) block_buf[i] = 8'h00;
    for (int i = 0; i < 8; i++) block_buf[56+i] = msg_bits[63-8*i -: 8];
    sha1_compress_block();
    for (int i = 0; i < 5; i++) begin
      dw.word  = chain_h[i];
      dw.index = 3'(i);
      dw.last  = (i == 4);
      pending_digest_words.push_back(dw);
    end
    sha1_restart();
  endfunction

  // ---------------------------------------------------------------------
  // Clock and run limit.
  // ---------------------------------------------------------------------
  initial begin
    forever #6 clk = ~clk;
  end

  // Far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Helpers shared by sender and receiver.
  // ---------------------------------------------------------------------
  // Gap length: mostly none, sometimes a few cycles, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Byte value biased toward all-zero, all-one and pad-lookalike bytes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      2: return PAD_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random backpressure with runs of full-speed ready.
  // ---------------------------------------------------------------------
  initial begin : ready_driver
    int unsigned run_len;
    int unsigned stall_len;
    forever begin
      run_len = $urandom_range(1, 40);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len == 0) stall_len = 1;
      out_ready <= 1'b0;
      repeat (stall_len) @(posedge clk);
    end
  end

  // Compare every output transaction with the oldest predicted word.
  // Signals are read right at the edge, i.e. the values the DUT saw.
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_digest_words.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d last %0b",
                                  out_digest_word, out_word_index, out_last_word));
      end else begin
        exp_w = pending_digest_words.pop_front();
        words_checked++;
        if (out_digest_word !== exp_w.word)
          report_mismatch($sformatf("word %0d: digest %h, expected %h",
                                    exp_w.index, out_digest_word, exp_w.word));
        if (out_word_index !== exp_w.index)
          report_mismatch($sformatf("word index %0d, expected %0d",
                                    out_word_index, exp_w.index));
        if (out_last_word !== exp_w.last)
          report_mismatch($sformatf("word %0d: last flag %0b, expected %0b",
                                    exp_w.index, out_last_word, exp_w.last));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Input side. Called at a rising edge; returns at the edge where the
  // transaction is accepted, with valid still high so a following item
  // can be presented without dropping it.
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [7:0] data, input logic has_byte,
                           input logic is_last);
    int unsigned gap;
    if (sender_gaps) begin
      gap = pick_gap();
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_has_byte  <= has_byte;
    in_is_last   <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: advance the model.
    sha1_take_item(data, has_byte, is_last);
    if (has_byte) begin
      bytes_sent++;
      cur_msg_len++;
    end
    if (!has_byte && !is_last) idle_sent++;
    if (is_last) begin
      msgs_closed++;
      if (cur_msg_len > longest_msg) longest_msg = cur_msg_len;
      cur_msg_len = 0;
    end
  endtask

  // Hold the sender until every predicted word has come out.
  task automatic wait_drained();
    if (pending_digest_words.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_digest_words.size() != 0) @(posedge clk);
    end
  endtask

  // Send a whole message, optionally with idle noise between bytes, and
  // close it either on the final byte or with a bare finish.
  task automatic send_message(input int unsigned len, input bit bare_close,
                              input int unsigned noise_pct);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, (i == len - 1) && !bare_close);
    end
    if (bare_close || len == 0) send_item(pick_byte(), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------
  // Bare finish straight after reset: digest of the empty message.
  task automatic test_empty_message();
    sender_gaps = 1'b0;
    send_item(8'h5a, 1'b0, 1'b1);
  endtask

  // Idle transactions carrying stray data bytes must not disturb the message.
  task automatic test_idle_items();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  // One-byte messages at both extremes, byte and close in one transaction.
  task automatic test_single_byte_close();
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
  endtask

  // The classic three-byte message, closed both ways, with a pause on the
  // sender until all digest words are out.
  task automatic test_abc_both_closes();
    sender_gaps = 1'b1;
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    wait_drained();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Random messages: mostly short, a good share around the padding and
  // block boundaries, some mid-size; random gaps, noise and pauses.
  // ---------------------------------------------------------------------
  task automatic test_random_messages();
    int unsigned pad_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int unsigned start_bytes;
    int unsigned len;
    int unsigned noise;
    bit          bare;
    start_bytes = bytes_sent;
    while ((bytes_sent - start_bytes) < 230 || msgs_closed < 14) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 12);
        4:          len = 0;
        5, 6, 7:    len = pad_lens[$urandom_range(0, 9)];
        default:    len = $urandom_range(13, 70);
      endcase
      bare        = $urandom_range(0, 1);
      noise       = ($urandom_range(0, 3) == 0) ? 10 : 0;
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_message(len, bare, noise);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    sender_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int unsigned settle;
    sha1_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_message();
    test_idle_items();
    test_single_byte_close();
    test_abc_both_closes();
    test_random_messages();

    // Drop valid, drain every digest word, then watch for stray output.
    in_valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 300) begin
      @(posedge clk);
      settle++;
    end

    $display("Hashed %0d messages (%0d bytes, longest %0d) with %0d idle transactions.",
             msgs_closed, bytes_sent, longest_msg, idle_sent);
    $display("Checked %0d digest words under random gaps and output stalls.",
             words_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/sha1h_pkg.sv
src/sha1h_front.sv
src/sha1h_fifo.sv
src/sha1h_core.sv
src/sha1_stream_hash_unit.sv
dv/testbench.sv
